[hw/rtl/i2cee_pkg.sv]
// Shared types, constants and helpers for the I2C EEPROM byte access master.
// No dependencies; used by the sequencer, the top level and the testbench.
package i2cee_pkg;

    // Register indexes on the configuration channel
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_ACK_WAIT_LIMIT = 1'b1;

    localparam logic [6:0] DEV_ADDR_RESET  = 7'd80;
    localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;

    // Step position: segment index in [6:3], sub-phase in [2:0]
    localparam logic [6:0] POS_IDLE = 7'd127;

    // Bus segments of a transaction
    typedef enum logic [2:0] {
        SEG_START = 3'd0,
        SEG_DEVW  = 3'd1,
        SEG_ADDR  = 3'd2,
        SEG_DATA  = 3'd3,
        SEG_DEVR  = 3'd4,
        SEG_ACK   = 3'd5,
        SEG_READ  = 3'd6,
        SEG_STOP  = 3'd7
    } t_seg;

    typedef struct packed {
        logic [6:0] pos;
        logic [3:0] bit_cnt;
        logic [7:0] shift;
        logic [7:0] ack_cnt;
        logic       op;
        logic [7:0] addr;
        logic [7:0] data;
        logic       scl;
        logic       sda;
        logic       ack_err;
        logic [7:0] rd_byte;
    } t_state;

    // Segment order of a byte write or a random read
    function automatic t_seg seg_code(input logic op, input logic [3:0] idx);
        t_seg s;
        s = SEG_STOP;
        if (op) begin
            case (idx)
                4'd0:    s = SEG_START;
                4'd1:    s = SEG_DEVW;
                4'd2:    s = SEG_ACK;
                4'd3:    s = SEG_ADDR;
                4'd4:    s = SEG_ACK;
                4'd5:    s = SEG_START;
                4'd6:    s = SEG_DEVR;
                4'd7:    s = SEG_ACK;
                4'd8:    s = SEG_READ;
                default: s = SEG_STOP;
            endcase
        end else begin
            case (idx)
                4'd0:    s = SEG_START;
                4'd1:    s = SEG_DEVW;
                4'd2:    s = SEG_ACK;
                4'd3:    s = SEG_ADDR;
                4'd4:    s = SEG_ACK;
                4'd5:    s = SEG_DATA;
                4'd6:    s = SEG_ACK;
                default: s = SEG_STOP;
            endcase
        end
        return s;
    endfunction

    // Move to sub-phase 0 of a segment, loading the byte to send
    function automatic t_state enter_seg(input t_state st, input logic [3:0] idx,
                                         input logic [6:0] dev);
        t_state n;
        t_seg   c;
        n = st;
        c = seg_code(st.op, idx);
        n.bit_cnt = 4'd0;
        n.ack_cnt = 8'd0;
        case (c)
            SEG_DEVW: n.shift = {dev, 1'b0};
            SEG_DEVR: n.shift = {dev, 1'b1};
            SEG_ADDR: n.shift = st.addr;
            SEG_DATA: n.shift = st.data;
            default:  n.shift = st.shift;
        endcase
        n.pos = {idx, 3'd0};
        return n;
    endfunction

endpackage

[hw/rtl/i2cee_if.sv]
// Handshake channels of the I2C EEPROM master: request, result, configuration.
// Uses nothing from the package; plain valid/ready with payload.
interface i2cee_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic       op;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic       sda_in;

    modport src (output valid, kind, op, word_address, write_data, sda_in, input ready);
    modport snk (input valid, kind, op, word_address, write_data, sda_in, output ready);
endinterface

interface i2cee_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;

    modport src (output valid, scl_level, sda_level, busy_res, done_res, read_data,
                 ack_missing, input ready);
    modport snk (input valid, scl_level, sda_level, busy_res, done_res, read_data,
                 ack_missing, output ready);
endinterface

interface i2cee_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport src (output valid, index, data, input ready);
    modport snk (input valid, index, data, output ready);
endinterface

[hw/rtl/i2cee_seq.sv]
// Next-state logic of the bus sequencer: one request moves one bus phase.
// Depends on i2cee_pkg (state struct, segment codes, enter_seg).
module i2cee_seq import i2cee_pkg::*; (
    input  t_state     i_state,
    input  logic       i_kind,
    input  logic       i_op,
    input  logic [7:0] i_word_address,
    input  logic [7:0] i_write_data,
    input  logic       i_sda_in,
    input  logic [6:0] i_dev_addr,
    input  logic [7:0] i_ack_limit,
    output t_state     o_state,
    output logic       o_done
);

    logic [3:0] idx;
    logic [2:0] sub;
    logic [3:0] idx_nx;
    logic [3:0] bit_inc;
    logic [7:0] shift_in;
    t_seg       seg;
    t_state     cmd;

    assign idx      = i_state.pos[6:3];
    assign sub      = i_state.pos[2:0];
    assign idx_nx   = idx + 4'd1;
    assign bit_inc  = i_state.bit_cnt + 4'd1;
    assign shift_in = {i_state.shift[6:0], i_sda_in};
    assign seg      = seg_code(i_state.op, idx);

    // Command latch: operands taken, error flag cleared
    always_comb begin
        cmd         = i_state;
        cmd.op      = i_op;
        cmd.addr    = i_word_address;
        cmd.data    = i_write_data;
        cmd.ack_err = 1'b0;
        cmd         = enter_seg(cmd, 4'd0, i_dev_addr);
    end

    // Phase sequencing
    always_comb begin
        o_state = i_state;
        o_done  = 1'b0;
        if (i_kind) begin
            if (i_state.pos == POS_IDLE) begin
                o_state = cmd;
            end
        end else if (i_state.pos != POS_IDLE) begin
            case (seg)
                SEG_START: begin
                    if (sub == 3'd0) begin
                        o_state.sda = 1'b1;
                        o_state.pos = i_state.pos + 7'd1;
                    end else if (sub == 3'd1) begin
                        o_state.scl = 1'b1;
                        o_state.pos = i_state.pos + 7'd1;
                    end else begin
                        o_state.sda = 1'b0;
                        o_state     = enter_seg(o_state, idx_nx, i_dev_addr);
                    end
                end
                SEG_ACK: begin
                    if (sub == 3'd0) begin
                        o_state.scl     = 1'b1;
                        o_state.ack_cnt = 8'd0;
                        o_state.pos     = i_state.pos + 7'd1;
                    end else if (i_sda_in && (i_state.ack_cnt < i_ack_limit)) begin
                        o_state.ack_cnt = i_state.ack_cnt + 8'd1;
                    end else begin
                        // timed out or acknowledged: carry on either way
                        if (i_sda_in) begin
                            o_state.ack_err = 1'b1;
                        end
                        o_state.scl = 1'b0;
                        o_state     = enter_seg(o_state, idx_nx, i_dev_addr);
                    end
                end
                SEG_READ: begin
                    if (sub == 3'd0) begin
                        o_state.scl = 1'b0;
                        o_state.pos = i_state.pos + 7'd1;
                    end else if (sub == 3'd1) begin
                        o_state.sda     = 1'b1;
                        o_state.bit_cnt = 4'd0;
                        o_state.pos     = i_state.pos + 7'd1;
                    end else if (sub == 3'd2) begin
                        o_state.scl = 1'b1;
                        o_state.pos = i_state.pos + 7'd1;
                    end else begin
                        // sample on the falling SCL edge, MSB first
                        o_state.shift   = shift_in;
                        o_state.scl     = 1'b0;
                        o_state.bit_cnt = bit_inc;
                        if (bit_inc >= 4'd8) begin
                            o_state.rd_byte = shift_in;
                            o_state         = enter_seg(o_state, idx_nx, i_dev_addr);
                        end else begin
                            o_state.pos = {idx, 3'd2};
                        end
                    end
                end
                SEG_STOP: begin
                    if (sub == 3'd0) begin
                        o_state.sda = 1'b0;
                        o_state.pos = i_state.pos + 7'd1;
                    end else if (sub == 3'd1) begin
                        o_state.scl = 1'b1;
                        o_state.pos = i_state.pos + 7'd1;
                    end else begin
                        o_state.sda     = 1'b1;
                        o_state.pos     = POS_IDLE;
                        o_state.bit_cnt = 4'd0;
                        o_state.ack_cnt = 8'd0;
                        o_done          = 1'b1;
                    end
                end
                default: begin
                    // byte send: device, address or data byte
                    if (sub == 3'd0) begin
                        o_state.scl = 1'b0;
                        o_state.pos = i_state.pos + 7'd1;
                    end else if (sub == 3'd1) begin
                        o_state.sda   = i_state.shift[7];
                        o_state.shift = {i_state.shift[6:0], 1'b0};
                        o_state.pos   = i_state.pos + 7'd1;
                    end else if (sub == 3'd2) begin
                        o_state.scl     = 1'b1;
                        o_state.bit_cnt = bit_inc;
                        o_state.pos     = (bit_inc >= 4'd8) ? {idx, 3'd3} : {idx, 3'd0};
                    end else if (sub == 3'd3) begin
                        o_state.scl = 1'b0;
                        o_state.pos = i_state.pos + 7'd1;
                    end else begin
                        o_state.sda = 1'b1;
                        o_state     = enter_seg(o_state, idx_nx, i_dev_addr);
                    end
                end
            endcase
        end
    end

endmodule

[hw/rtl/i2c_eeprom_byte_access_master_unit.sv]
// I2C EEPROM byte access master, top level: state and result registers.
// Depends on i2cee_pkg, the i2cee_*_if interfaces and i2cee_seq.
// The result is registered: it appears in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the result register frees a slot when taken.
// Reset (synchronous, active low): idle, lines released, registers at defaults.
module i2c_eeprom_byte_access_master_unit import i2cee_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cee_req_if.snk    i_req,
    i2cee_cfg_if.snk    i_cfg,
    i2cee_res_if.src    o_res
);

    t_state     r_state;
    t_state     n_state;
    logic       seq_done;
    logic [6:0] r_dev_addr;
    logic [7:0] r_ack_limit;
    logic       r_out_valid;
    logic       r_done;
    logic       req_acc;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign req_acc     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    i2cee_seq u_seq (
        .i_state        (r_state),
        .i_kind         (i_req.kind),
        .i_op           (i_req.op),
        .i_word_address (i_req.word_address),
        .i_write_data   (i_req.write_data),
        .i_sda_in       (i_req.sda_in),
        .i_dev_addr     (r_dev_addr),
        .i_ack_limit    (r_ack_limit),
        .o_state        (n_state),
        .o_done         (seq_done)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= DEV_ADDR_RESET;
            r_ack_limit <= ACK_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DEVICE_ADDRESS: r_dev_addr  <= i_cfg.data[6:0];
                CFG_ACK_WAIT_LIMIT: r_ack_limit <= i_cfg.data;
                default:            r_ack_limit <= r_ack_limit;
            endcase
        end
    end

    // Sequencer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pos     <= POS_IDLE;
            r_state.bit_cnt <= 4'd0;
            r_state.shift   <= 8'd0;
            r_state.ack_cnt <= 8'd0;
            r_state.op      <= 1'b0;
            r_state.addr    <= 8'd0;
            r_state.data    <= 8'd0;
            r_state.scl     <= 1'b1;
            r_state.sda     <= 1'b1;
            r_state.ack_err <= 1'b0;
            r_state.rd_byte <= 8'd0;
            r_out_valid     <= 1'b0;
            r_done          <= 1'b0;
        end else if (req_acc) begin
            r_state     <= n_state;
            r_done      <= seq_done;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result fields follow the state left by the last request
    assign o_res.valid       = r_out_valid;
    assign o_res.scl_level   = r_state.scl;
    assign o_res.sda_level   = r_state.sda;
    assign o_res.busy_res    = (r_state.pos != POS_IDLE);
    assign o_res.done_res    = r_done;
    assign o_res.read_data   = r_state.rd_byte;
    assign o_res.ack_missing = r_state.ack_err;

endmodule

[test/tb_i2c_eeprom_byte_access_master_unit.sv]
// Self-checking bench for the I2C EEPROM byte access master: a directed table, then
// random byte writes and random reads under several register settings.
// Depends on i2cee_pkg, the i2cee_*_if interfaces and the top level under hw/rtl.
module tb_i2c_eeprom_byte_access_master_unit;
    import i2cee_pkg::*;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam int NUM_PHASES       = 6;
    localparam int PHASE_ITEMS      = 85;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int SETTLE_CYCLES    = 4;

    typedef struct packed {
        logic       kind;
        logic       op;
        logic [7:0] word_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_req;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } t_obs;

    typedef struct packed {
        t_req req;
        logic typed;
        t_obs obs;
    } t_row;

    // How the emulated EEPROM answers on SDA for one transaction
    typedef enum logic [1:0] {
        SLAVE_ACKS,
        SLAVE_NOISY,
        SLAVE_SILENT
    } t_slave_style;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cee_req_if req_ch ();
    i2cee_res_if res_ch ();
    i2cee_cfg_if cfg_ch ();

    i2c_eeprom_byte_access_master_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bus sequencer mirror
    logic [6:0] bus_pos;
    logic [3:0] bits_done;
    logic [7:0] tx_byte;
    logic [7:0] ack_ticks;
    logic       cur_op;
    logic [7:0] cur_addr;
    logic [7:0] cur_data;
    logic       scl_drv;
    logic       sda_drv;
    logic       ack_lost;
    logic [7:0] rd_byte;
    logic [6:0] dev_addr;
    logic [7:0] ack_limit;

    t_obs         bus_obs_q[$];
    t_row         directed_rows[$];
    t_slave_style slave_style = SLAVE_ACKS;
    logic         no_idling = 1'b0;
    logic         hold_request = 1'b0;
    int           calm_items = 0;
    int           mismatches = 0;
    int           results_checked = 0;
    int           requests_sent = 0;
    int           transfers_done = 0;
    int           reads_done = 0;
    int           ack_timeouts = 0;
    int           ignored_cmds = 0;
    int           settings_used = 1;
    int           stalled_cycles = 0;

    // Segment order: both transactions share the first five segments
    function automatic t_seg plan_segment(input logic op, input logic [3:0] idx);
        case (idx)
            4'd0:       return SEG_START;
            4'd1:       return SEG_DEVW;
            4'd2, 4'd4: return SEG_ACK;
            4'd3:       return SEG_ADDR;
            4'd5:       return op ? SEG_START : SEG_DATA;
            4'd6:       return op ? SEG_DEVR : SEG_ACK;
            4'd7:       return op ? SEG_ACK : SEG_STOP;
            4'd8:       return op ? SEG_READ : SEG_STOP;
            default:    return SEG_STOP;
        endcase
    endfunction

    // Jump to the start of a segment, loading the byte it shifts out
    function automatic void load_segment(input logic [3:0] idx);
        bits_done = 4'd0;
        ack_ticks = 8'd0;
        case (plan_segment(cur_op, idx))
            SEG_DEVW: tx_byte = {dev_addr, 1'b0};
            SEG_DEVR: tx_byte = {dev_addr, 1'b1};
            SEG_ADDR: tx_byte = cur_addr;
            SEG_DATA: tx_byte = cur_data;
            default:  ;
        endcase
        bus_pos = {idx, 3'd0};
    endfunction

    // One request against the mirror; returns the bus state it leaves behind
    function automatic t_obs predict_bus(input t_req r);
        t_obs       o;
        logic [3:0] seg_idx;
        logic [2:0] sub_step;
        t_seg       seg;
        o.done_res = 1'b0;
        seg_idx  = bus_pos[6:3];
        sub_step = bus_pos[2:0];
        seg      = plan_segment(cur_op, seg_idx);
        if (r.kind == KIND_CMD) begin
            if (bus_pos == POS_IDLE) begin
                cur_op   = r.op;
                cur_addr = r.word_address;
                cur_data = r.write_data;
                ack_lost = 1'b0;
                load_segment(4'd0);
            end else begin
                ignored_cmds++;
            end
        end else if (bus_pos != POS_IDLE) begin
            case (seg)
                SEG_START: begin
                    if (sub_step == 3'd0) begin
                        sda_drv = 1'b1;
                        bus_pos = bus_pos + 7'd1;
                    end else if (sub_step == 3'd1) begin
                        scl_drv = 1'b1;
                        bus_pos = bus_pos + 7'd1;
                    end else begin
                        sda_drv = 1'b0;
                        load_segment(seg_idx + 4'd1);
                    end
                end
                SEG_ACK: begin
                    if (sub_step == 3'd0) begin
                        scl_drv   = 1'b1;
                        ack_ticks = 8'd0;
                        bus_pos   = bus_pos + 7'd1;
                    end else if (r.sda_in && ack_ticks < ack_limit) begin
                        ack_ticks = ack_ticks + 8'd1;
                    end else begin
                        if (r.sda_in) begin
                            ack_lost = 1'b1;
                            ack_timeouts++;
                        end
                        scl_drv = 1'b0;
                        load_segment(seg_idx + 4'd1);
                    end
                end
                SEG_READ: begin
                    if (sub_step == 3'd0) begin
                        scl_drv = 1'b0;
                        bus_pos = bus_pos + 7'd1;
                    end else if (sub_step == 3'd1) begin
                        sda_drv   = 1'b1;
                        bits_done = 4'd0;
                        bus_pos   = bus_pos + 7'd1;
                    end else if (sub_step == 3'd2) begin
                        scl_drv = 1'b1;
                        bus_pos = bus_pos + 7'd1;
                    end else begin
                        // bit sampled as SCL is pulled low
                        tx_byte   = {tx_byte[6:0], r.sda_in};
                        scl_drv   = 1'b0;
                        bits_done = bits_done + 4'd1;
                        if (bits_done >= 4'd8) begin
                            rd_byte = tx_byte;
                            load_segment(seg_idx + 4'd1);
                        end else begin
                            bus_pos = {seg_idx, 3'd2};
                        end
                    end
                end
                SEG_STOP: begin
                    if (sub_step == 3'd0) begin
                        sda_drv = 1'b0;
                        bus_pos = bus_pos + 7'd1;
                    end else if (sub_step == 3'd1) begin
                        scl_drv = 1'b1;
                        bus_pos = bus_pos + 7'd1;
                    end else begin
                        sda_drv    = 1'b1;
                        bus_pos    = POS_IDLE;
                        bits_done  = 4'd0;
                        ack_ticks  = 8'd0;
                        o.done_res = 1'b1;
                        transfers_done++;
                        if (cur_op == OP_READ) reads_done++;
                    end
                end
                default: begin
                    // byte out, MSB first: SCL low, set SDA, SCL high; then release
                    if (sub_step == 3'd0) begin
                        scl_drv = 1'b0;
                        bus_pos = bus_pos + 7'd1;
                    end else if (sub_step == 3'd1) begin
                        sda_drv = tx_byte[7];
                        tx_byte = {tx_byte[6:0], 1'b0};
                        bus_pos = bus_pos + 7'd1;
                    end else if (sub_step == 3'd2) begin
                        scl_drv   = 1'b1;
                        bits_done = bits_done + 4'd1;
                        bus_pos   = (bits_done >= 4'd8) ? {seg_idx, 3'd3} : {seg_idx, 3'd0};
                    end else if (sub_step == 3'd3) begin
                        scl_drv = 1'b0;
                        bus_pos = bus_pos + 7'd1;
                    end else begin
                        sda_drv = 1'b1;
                        load_segment(seg_idx + 4'd1);
                    end
                end
            endcase
        end
        o.scl_level   = scl_drv;
        o.sda_level   = sda_drv;
        o.busy_res    = (bus_pos != POS_IDLE);
        o.read_data   = rd_byte;
        o.ack_missing = ack_lost;
        return o;
    endfunction

    // Byte with its extremes weighted up
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Commands when idle, ticks when busy, with some noise; SDA follows the slave style
    function automatic t_req pick_item();
        t_req r;
        r.kind         = KIND_TICK;
        r.op           = 1'($urandom_range(0, 1));
        r.word_address = pick_byte();
        r.write_data   = pick_byte();
        r.sda_in       = 1'($urandom_range(0, 1));
        if (bus_pos == POS_IDLE) begin
            if ($urandom_range(0, 9) != 0) r.kind = KIND_CMD;
        end else begin
            if ($urandom_range(0, 49) == 0) r.kind = KIND_CMD;
            if (slave_style == SLAVE_SILENT) begin
                r.sda_in = 1'b1;
            end else if (slave_style == SLAVE_ACKS &&
                         plan_segment(cur_op, bus_pos[6:3]) == SEG_ACK) begin
                r.sda_in = ($urandom_range(0, 3) == 0);
            end
        end
        return r;
    endfunction

    // Offer one request, with an occasional gap before it, and log its expected result
    task automatic send_request(input t_req r, input logic typed, input t_obs typed_obs);
        int   gap;
        t_obs got;
        if (calm_items > 0) begin
            calm_items--;
        end else if (!no_idling && $urandom_range(0, 24) == 0) begin
            calm_items = $urandom_range(20, 50);
        end else if (!no_idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= r.kind;
        req_ch.op           <= r.op;
        req_ch.word_address <= r.word_address;
        req_ch.write_data   <= r.write_data;
        req_ch.sda_in       <= r.sda_in;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        got = predict_bus(r);
        bus_obs_q.push_back(typed ? typed_obs : got);
        requests_sent++;
    endtask

    // Both register writes back to back, valid held high between them
    task automatic configure(input logic [7:0] dev_word, input logic [7:0] limit_word);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_DEVICE_ADDRESS;
        cfg_ch.data  <= dev_word;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        dev_addr = dev_word[6:0];
        cfg_ch.index <= CFG_ACK_WAIT_LIMIT;
        cfg_ch.data  <= limit_word;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        ack_limit = limit_word;
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Wait out every pending result, then let the outputs settle
    task automatic wait_for_drain();
        while (bus_obs_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_obs want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (bus_obs_q.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none, got scl=%0b sda=%0b busy=%0b done=%0b",
                         $time, res_ch.scl_level, res_ch.sda_level, res_ch.busy_res,
                         res_ch.done_res);
            end else begin
                want = bus_obs_q.pop_front();
                check_field("scl_level", 8'(want.scl_level), 8'(res_ch.scl_level));
                check_field("sda_level", 8'(want.sda_level), 8'(res_ch.sda_level));
                check_field("busy_res", 8'(want.busy_res), 8'(res_ch.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(res_ch.done_res));
                check_field("read_data", want.read_data, res_ch.read_data);
                check_field("ack_missing", 8'(want.ack_missing), 8'(res_ch.ack_missing));
                results_checked++;
            end
        end
    end

    // Result sink: random stall bursts, calm stretches, one long hold-off
    initial begin : result_sink
        int   stall_left;
        int   calm_left;
        logic hold_taken;
        stall_left = 0;
        calm_left  = 0;
        hold_taken = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if (!no_idling) begin
                    case ($urandom_range(0, 15))
                        0, 1, 2: stall_left = $urandom_range(1, 10);
                        3:       calm_left = $urandom_range(20, 60);
                        default: ;
                    endcase
                end
            end
        end
    end

    // Watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_i2c_eeprom_byte_access_master_unit: errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_req item;
        t_obs none;
        int   phase_items;
        int   pick;
        logic counts;
        none = '0;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.kind         <= KIND_TICK;
        req_ch.op           <= OP_WRITE;
        req_ch.word_address <= 8'h00;
        req_ch.write_data   <= 8'h00;
        req_ch.sda_in       <= 1'b1;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_DEVICE_ADDRESS;
        cfg_ch.data         <= 8'h00;

        // mirror state after reset
        bus_pos   = POS_IDLE;
        bits_done = 4'd0;
        tx_byte   = 8'h00;
        ack_ticks = 8'h00;
        cur_op    = OP_WRITE;
        cur_addr  = 8'h00;
        cur_data  = 8'h00;
        scl_drv   = 1'b1;
        sda_drv   = 1'b1;
        ack_lost  = 1'b0;
        rd_byte   = 8'h00;
        dev_addr  = DEV_ADDR_RESET;
        ack_limit = ACK_LIMIT_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle ticks, a write command, a command while busy, the start condition
        directed_rows.push_back(t_row'{t_req'{KIND_TICK, OP_WRITE, 8'h00, 8'h00, 1'b0},
                                       1'b1, t_obs'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}});
        directed_rows.push_back(t_row'{t_req'{KIND_TICK, OP_READ, 8'hFF, 8'hFF, 1'b1},
                                       1'b1, t_obs'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}});
        directed_rows.push_back(t_row'{t_req'{KIND_CMD, OP_WRITE, 8'hFF, 8'h00, 1'b0},
                                       1'b1, t_obs'{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}});
        directed_rows.push_back(t_row'{t_req'{KIND_CMD, OP_READ, 8'h00, 8'hFF, 1'b1},
                                       1'b1, t_obs'{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}});
        directed_rows.push_back(t_row'{t_req'{KIND_TICK, OP_WRITE, 8'h00, 8'h00, 1'b1},
                                       1'b1, t_obs'{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}});
        directed_rows.push_back(t_row'{t_req'{KIND_TICK, OP_WRITE, 8'h00, 8'h00, 1'b0},
                                       1'b1, t_obs'{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}});
        directed_rows.push_back(t_row'{t_req'{KIND_TICK, OP_WRITE, 8'h00, 8'h00, 1'b1},
                                       1'b1, t_obs'{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}});
        // first device-byte bits, checked against the mirror
        for (int i = 0; i < 15; i++) begin
            directed_rows.push_back(t_row'{t_req'{KIND_TICK, OP_WRITE, 8'h00, 8'h00,
                                                  1'(i % 2)}, 1'b0, none});
        end
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].obs);
        end

        // Random transactions, one register setting per phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                req_ch.valid <= 1'b0;
                wait_for_drain();
                case (ph)
                    1:       configure(8'h00, 8'h00);
                    2:       configure(8'hFF, 8'hFF);
                    3:       configure(8'($urandom_range(0, 255)), 8'h01);
                    4:       configure({1'b0, DEV_ADDR_RESET}, 8'($urandom_range(2, 12)));
                    default: configure(8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)));
                endcase
            end
            if (ph == 0) hold_request <= 1'b1;
            if (ph == NUM_PHASES - 1) no_idling <= 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS || bus_pos != POS_IDLE) begin
                item = pick_item();
                counts = ((item.kind == KIND_CMD) == (bus_pos == POS_IDLE));
                if (item.kind == KIND_CMD && bus_pos == POS_IDLE) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 3) slave_style = SLAVE_SILENT;
                    else if (pick < 8) slave_style = SLAVE_NOISY;
                    else slave_style = SLAVE_ACKS;
                end
                send_request(item, 1'b0, none);
                if (counts) phase_items++;
            end
        end

        req_ch.valid <= 1'b0;
        wait_for_drain();
        $display("Sent %0d requests, checked %0d results over %0d register settings.",
                 requests_sent, results_checked, settings_used);
        $display("Finished %0d transfers (%0d reads), %0d ack timeouts, %0d busy commands.",
                 transfers_done, reads_done, ack_timeouts, ignored_cmds);
        if (mismatches == 0) begin
            $display("tb_i2c_eeprom_byte_access_master_unit: clean");
        end else begin
            $display("tb_i2c_eeprom_byte_access_master_unit: errors");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/i2cee_pkg.sv
hw/rtl/i2cee_if.sv
hw/rtl/i2cee_seq.sv
hw/rtl/i2c_eeprom_byte_access_master_unit.sv
test/tb_i2c_eeprom_byte_access_master_unit.sv
